// ===== sv/rmss_pkg.sv =====
// package for the running median split sum block: types and constants
package rmss_pkg;

    // default entries per heap
    localparam int unsigned HalfCapacityDefault = 512;
    localparam int unsigned KeyWidth = 32;
    localparam int unsigned WeightWidth = 16;
    localparam int unsigned EntryWidth = KeyWidth + WeightWidth;
    localparam int unsigned DiffWidth = 26;

    // one stored heap entry
    typedef struct packed {
        logic [KeyWidth-1:0]    key;
        logic [WeightWidth-1:0] weight;
    } entry_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TOP_RD,
        ST_TOP_CHK,
        ST_PUSH_RD,
        ST_PUSH_CHK,
        ST_PUSH_WR,
        ST_SIFT_RD,
        ST_SIFT_RD2,
        ST_SIFT_CHK,
        ST_SIFT_WR,
        ST_DONE
    } state_t;

endpackage

// ===== sv/running_median_split_sum_top.sv =====
// top level of the running median split sum block: two heaps in memories and a sequencer
// Each accepted item moves through a sequencer that walks the two heaps. The heaps are held
// in two single-port synchronous memories. After the accept, the sequencer reads and then
// checks the root of the other heap. The push into the growing half then reads and checks
// the parent at each level climbed and ends in a write. An item that crosses the boundary
// adds a sift-down from the root of the other heap, which reads the left and the right
// child at each level descended and ends in a write. The result is then formed in ST_DONE.
// A rejected item (both halves full) goes from the accept straight to ST_DONE. The result
// sits in an output register. The next item can be taken in the cycle after the result is
// handed off. The memories need no clearing after reset, because only entries below each
// count are ever used.
module running_median_split_sum_top #(
    parameter int unsigned HALF_CAPACITY = rmss_pkg::HalfCapacityDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // key [31:0], weight [47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // sum_difference [25:0], zeros above
    output logic        m_tuser     // overflow
);
    import rmss_pkg::*;

    localparam int unsigned AW = (HALF_CAPACITY > 1) ? $clog2(HALF_CAPACITY) : 1;
    localparam int unsigned CW = $clog2(HALF_CAPACITY + 1);
    localparam int unsigned SW = CW + WeightWidth;

    // heap memories: lo_mem lower (max), up_mem upper (min)
    entry_t lo_mem [HALF_CAPACITY];
    entry_t up_mem [HALF_CAPACITY];
    entry_t lo_rd_reg, up_rd_reg;

    state_t state_reg, state_next;
    logic [CW-1:0] lo_cnt_reg, lo_cnt_next, up_cnt_reg, up_cnt_next;
    logic [SW-1:0] lo_sum_reg, lo_sum_next, up_sum_reg, up_sum_next;
    entry_t in_reg, in_next;          // accepted item being inserted
    entry_t push_reg, push_next;      // entry pushed up
    entry_t sift_reg, sift_next;      // entry sifted down
    entry_t left_reg, left_next;      // left child held during sift
    logic push_lo_reg, push_lo_next;  // push heap is lower
    logic do_sift_reg, do_sift_next;
    logic [AW-1:0] pi_reg, pi_next;   // push hole index
    logic [CW:0]   si_reg, si_next;   // sift hole index
    logic [CW-1:0] sift_cnt_reg, sift_cnt_next;
    logic ovf_reg, ovf_next;
    logic [DiffWidth-1:0] diff_reg, diff_next;
    logic out_valid_reg, out_valid_next;

    // memory port controls
    logic lo_we, up_we;
    logic [AW-1:0] lo_addr, up_addr;
    entry_t lo_wd, up_wd;

    // shared derived values
    logic [AW-1:0] parent;
    logic [CW+1:0] lchild, rchild;
    logic [SW-1:0] dsum;
    entry_t top;
    entry_t rd_sift;

    assign parent = AW'((pi_reg - AW'(1)) >> 1);
    assign lchild = {si_reg, 1'b1};
    assign rchild = lchild + (CW+2)'(1);
    assign top = push_lo_reg ? up_rd_reg : lo_rd_reg;   // top of the sift heap
    assign rd_sift = push_lo_reg ? up_rd_reg : lo_rd_reg;

    // sequencer
    always_comb begin
        state_next = state_reg;
        lo_cnt_next = lo_cnt_reg;
        up_cnt_next = up_cnt_reg;
        lo_sum_next = lo_sum_reg;
        up_sum_next = up_sum_reg;
        in_next = in_reg;
        push_next = push_reg;
        sift_next = sift_reg;
        left_next = left_reg;
        push_lo_next = push_lo_reg;
        do_sift_next = do_sift_reg;
        pi_next = pi_reg;
        si_next = si_reg;
        sift_cnt_next = sift_cnt_reg;
        ovf_next = ovf_reg;
        diff_next = diff_reg;
        out_valid_next = out_valid_reg;
        lo_we = 1'b0;
        up_we = 1'b0;
        lo_addr = '0;
        up_addr = '0;
        lo_wd = push_reg;
        up_wd = push_reg;
        dsum = '0;
        s_tready = 1'b0;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                s_tready = !out_valid_reg;
                if (s_tvalid && !out_valid_reg) begin
                    in_next = entry_t'({s_tdata[31:0], s_tdata[47:32]});
                    ovf_next = 1'b0;
                    push_lo_next = (lo_cnt_reg == up_cnt_reg);
                    if (lo_cnt_reg == up_cnt_reg && lo_cnt_reg >= CW'(HALF_CAPACITY)) begin
                        ovf_next = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_TOP_RD;
                    end
                end
            end
            ST_TOP_RD: begin
                // read root of the other heap (both addresses 0)
                state_next = ST_TOP_CHK;
            end
            ST_TOP_CHK: begin
                if (push_lo_reg) begin
                    do_sift_next = (up_cnt_reg != '0) && (up_rd_reg.key < in_reg.key);
                end else begin
                    do_sift_next = (in_reg.key < lo_rd_reg.key);
                end
                if (push_lo_reg ? ((up_cnt_reg != '0) && (up_rd_reg.key < in_reg.key))
                                : (in_reg.key < lo_rd_reg.key)) begin
                    push_next = top;
                    sift_next = in_reg;
                    if (push_lo_reg) begin
                        lo_sum_next = lo_sum_reg + SW'(top.weight);
                        up_sum_next = up_sum_reg - SW'(top.weight) + SW'(in_reg.weight);
                    end else begin
                        up_sum_next = up_sum_reg + SW'(top.weight);
                        lo_sum_next = lo_sum_reg - SW'(top.weight) + SW'(in_reg.weight);
                    end
                end else begin
                    push_next = in_reg;
                    if (push_lo_reg) lo_sum_next = lo_sum_reg + SW'(in_reg.weight);
                    else up_sum_next = up_sum_reg + SW'(in_reg.weight);
                end
                pi_next = AW'(push_lo_reg ? lo_cnt_reg : up_cnt_reg);
                sift_cnt_next = push_lo_reg ? up_cnt_reg : lo_cnt_reg;
                si_next = '0;
                state_next = ST_PUSH_RD;
            end
            ST_PUSH_RD: begin
                if (pi_reg == '0) begin
                    state_next = ST_PUSH_WR;
                end else begin
                    lo_addr = parent;
                    up_addr = parent;
                    state_next = ST_PUSH_CHK;
                end
            end
            ST_PUSH_CHK: begin
                // move parent down if new entry ranks above it
                if (push_lo_reg ? (push_reg.key > lo_rd_reg.key)
                                : (push_reg.key < up_rd_reg.key)) begin
                    lo_addr = pi_reg;
                    up_addr = pi_reg;
                    lo_wd = lo_rd_reg;
                    up_wd = up_rd_reg;
                    lo_we = push_lo_reg;
                    up_we = !push_lo_reg;
                    pi_next = parent;
                    state_next = ST_PUSH_RD;
                end else begin
                    state_next = ST_PUSH_WR;
                end
            end
            ST_PUSH_WR: begin
                lo_addr = pi_reg;
                up_addr = pi_reg;
                lo_we = push_lo_reg;
                up_we = !push_lo_reg;
                if (push_lo_reg) lo_cnt_next = lo_cnt_reg + CW'(1);
                else up_cnt_next = up_cnt_reg + CW'(1);
                state_next = do_sift_reg ? ST_SIFT_RD : ST_DONE;
            end
            ST_SIFT_RD: begin
                // read left child
                if (lchild >= (CW+2)'(sift_cnt_reg)) begin
                    state_next = ST_SIFT_WR;
                end else begin
                    lo_addr = AW'(lchild);
                    up_addr = AW'(lchild);
                    state_next = ST_SIFT_RD2;
                end
            end
            ST_SIFT_RD2: begin
                // latch left, read right
                left_next = rd_sift;
                lo_addr = AW'(rchild);
                up_addr = AW'(rchild);
                state_next = ST_SIFT_CHK;
            end
            ST_SIFT_CHK: begin
                // pick child; right valid only below count
                if (rchild < (CW+2)'(sift_cnt_reg) &&
                    (push_lo_reg ? (rd_sift.key < left_reg.key)
                                 : (rd_sift.key > left_reg.key))) begin
                    if (push_lo_reg ? (rd_sift.key < sift_reg.key)
                                    : (rd_sift.key > sift_reg.key)) begin
                        lo_addr = AW'(si_reg);
                        up_addr = AW'(si_reg);
                        lo_wd = rd_sift;
                        up_wd = rd_sift;
                        lo_we = !push_lo_reg;
                        up_we = push_lo_reg;
                        si_next = (CW+1)'(rchild);
                        state_next = ST_SIFT_RD;
                    end else begin
                        state_next = ST_SIFT_WR;
                    end
                end else if (push_lo_reg ? (left_reg.key < sift_reg.key)
                                         : (left_reg.key > sift_reg.key)) begin
                    lo_addr = AW'(si_reg);
                    up_addr = AW'(si_reg);
                    lo_wd = left_reg;
                    up_wd = left_reg;
                    lo_we = !push_lo_reg;
                    up_we = push_lo_reg;
                    si_next = (CW+1)'(lchild);
                    state_next = ST_SIFT_RD;
                end else begin
                    state_next = ST_SIFT_WR;
                end
            end
            ST_SIFT_WR: begin
                lo_addr = AW'(si_reg);
                up_addr = AW'(si_reg);
                lo_wd = sift_reg;
                up_wd = sift_reg;
                lo_we = !push_lo_reg;
                up_we = push_lo_reg;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                dsum = (lo_sum_reg >= up_sum_reg) ? (lo_sum_reg - up_sum_reg)
                                                  : (up_sum_reg - lo_sum_reg);
                diff_next = DiffWidth'(dsum);
                out_valid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // heap memories, one port each, registered read
    always_ff @(posedge aclk) begin
        if (lo_we) lo_mem[lo_addr] <= lo_wd;
        lo_rd_reg <= lo_mem[lo_addr];
    end

    always_ff @(posedge aclk) begin
        if (up_we) up_mem[up_addr] <= up_wd;
        up_rd_reg <= up_mem[up_addr];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            lo_cnt_reg <= '0;
            up_cnt_reg <= '0;
            lo_sum_reg <= '0;
            up_sum_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            lo_cnt_reg <= lo_cnt_next;
            up_cnt_reg <= up_cnt_next;
            lo_sum_reg <= lo_sum_next;
            up_sum_reg <= up_sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        in_reg <= in_next;
        push_reg <= push_next;
        sift_reg <= sift_next;
        left_reg <= left_next;
        push_lo_reg <= push_lo_next;
        do_sift_reg <= do_sift_next;
        pi_reg <= pi_next;
        si_reg <= si_next;
        sift_cnt_reg <= sift_cnt_next;
        ovf_reg <= ovf_next;
        diff_reg <= diff_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {6'b0, diff_reg};
    assign m_tuser = ovf_reg;

    // lower half never smaller than upper, never more than one larger
    assert property (@(posedge aclk) disable iff (!aresetn)
        (lo_cnt_reg == up_cnt_reg) || (lo_cnt_reg == up_cnt_reg + CW'(1)))
        else $error("half counts out of balance");

    // no new item while a result waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !s_tready)
        else $error("item taken while result pending");

    // a result that was not taken stays
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("pending result changed");

endmodule

// ===== test/running_median_split_sum_top_test.sv =====
// testbench for the running median split sum block: heap predictor and stream checks
module running_median_split_sum_top_test;
    import rmss_pkg::*;

    localparam int unsigned HalfCap = HalfCapacityDefault;
    localparam int NumRandom = 1630;
    localparam int QuietTail = 150;

    typedef struct {
        logic [KeyWidth-1:0]    key;
        logic [WeightWidth-1:0] weight;
        bit                     drain_first;
    } pending_t;

    typedef struct {
        logic [DiffWidth-1:0] diff;
        logic                 overflow;
    } split_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;    // key [31:0], weight [47:32]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // sum_difference [25:0], zeros above
    logic        m_tuser;    // overflow

    pending_t      item_queue[$];
    split_result_t expected_results[$];
    int            errors = 0;
    bit            quiet = 0;

    // predictor state: two heaps, counts and exact sums
    entry_t  lo_heap[HalfCap];
    entry_t  hi_heap[HalfCap];
    int      lo_cnt = 0;
    int      hi_cnt = 0;
    longint  lo_sum = 0;
    longint  hi_sum = 0;

    running_median_split_sum_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    function automatic bit outranks(entry_t a, entry_t b, bit is_max);
        return is_max ? (a.key > b.key) : (a.key < b.key);
    endfunction

    // sift-up insert at position cnt
    task automatic heap_insert(ref entry_t h[HalfCap], input int cnt, input entry_t e,
                               input bit is_max);
        int i;
        int p;
        i = cnt;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!outranks(e, h[p], is_max)) break;
            h[i] = h[p];
            i = p;
        end
        h[i] = e;
    endtask

    // replace the root and sift down
    task automatic heap_swap_root(ref entry_t h[HalfCap], input int cnt, input entry_t e,
                                  input bit is_max);
        int i;
        int l;
        int c;
        i = 0;
        forever begin
            l = 2 * i + 1;
            if (l >= cnt) break;
            c = l;
            if (l + 1 < cnt && outranks(h[l + 1], h[l], is_max)) c = l + 1;
            if (!outranks(h[c], e, is_max)) break;
            h[i] = h[c];
            i = c;
        end
        h[i] = e;
    endtask

    // advance the median split by one item and queue the expected difference
    task automatic predict_split(input logic [47:0] data);
        entry_t        e;
        entry_t        m;
        split_result_t r;
        longint        d;
        e.key = data[31:0];
        e.weight = data[47:32];
        r.overflow = 1'b0;
        if (lo_cnt == hi_cnt) begin
            if (lo_cnt >= HalfCap) begin
                r.overflow = 1'b1;
            end else if (hi_cnt > 0 && hi_heap[0].key < e.key) begin
                m = hi_heap[0];
                heap_insert(lo_heap, lo_cnt, m, 1'b1);
                lo_cnt++;
                heap_swap_root(hi_heap, hi_cnt, e, 1'b0);
                lo_sum += m.weight;
                hi_sum = hi_sum - m.weight + e.weight;
            end else begin
                heap_insert(lo_heap, lo_cnt, e, 1'b1);
                lo_cnt++;
                lo_sum += e.weight;
            end
        end else if (e.key < lo_heap[0].key) begin
            m = lo_heap[0];
            heap_insert(hi_heap, hi_cnt, m, 1'b0);
            hi_cnt++;
            heap_swap_root(lo_heap, lo_cnt, e, 1'b1);
            hi_sum += m.weight;
            lo_sum = lo_sum - m.weight + e.weight;
        end else begin
            heap_insert(hi_heap, hi_cnt, e, 1'b0);
            hi_cnt++;
            hi_sum += e.weight;
        end
        d = (lo_sum >= hi_sum) ? lo_sum - hi_sum : hi_sum - lo_sum;
        r.diff = d[DiffWidth-1:0];
        expected_results.push_back(r);
    endtask

    task automatic add_item(input logic [31:0] k, input logic [15:0] w, input bit drain);
        pending_t p;
        p.key = k;
        p.weight = w;
        p.drain_first = drain;
        item_queue.push_back(p);
    endtask

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // sender: presents queued items with random idle bursts
    int src_gap = 0;
    always @(posedge aclk) begin
        logic        next_valid;
        logic [47:0] next_data;
        next_valid = s_tvalid;
        next_data = s_tdata;
        if (!aresetn) begin
            next_valid = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_split(s_tdata);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (item_queue.size() > 0 &&
                             (!item_queue[0].drain_first || expected_results.size() == 0)) begin
                    next_valid = 1'b1;
                    next_data = {item_queue[0].weight, item_queue[0].key};
                    void'(item_queue.pop_front());
                    if (item_queue.size() < QuietTail) quiet <= 1'b1;
                    if (!quiet && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 15);
                end
            end
        end
        s_tvalid <= next_valid;
        s_tdata <= next_data;
    end

    // receiver: random stall bursts and result check
    int sink_stall = 0;
    always @(posedge aclk) begin
        split_result_t r;
        logic          next_ready;
        next_ready = 1'b1;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected item, actual diff %0d overflow %0b", $time,
                         m_tdata[25:0], m_tuser);
                errors++;
            end else begin
                r = expected_results.pop_front();
                if (m_tdata[25:0] !== r.diff) begin
                    $display("%0t: sum_difference expected %0d actual %0d", $time, r.diff,
                             m_tdata[25:0]);
                    errors++;
                end
                if (m_tuser !== r.overflow) begin
                    $display("%0t: overflow expected %0b actual %0b", $time, r.overflow,
                             m_tuser);
                    errors++;
                end
            end
        end
        if (sink_stall > 0) begin
            sink_stall--;
            next_ready = 1'b0;
        end else if (aresetn && !quiet && $urandom_range(0, 11) == 0) begin
            sink_stall = $urandom_range(1, 15);
            next_ready = 1'b0;
        end
        m_tready <= next_ready;
    end

    // stimulus and end of run
    initial begin
        logic [31:0] k;
        logic [15:0] w;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        aresetn = 1'b0;

        // directed: extremes, both crossing directions, equal keys
        add_item(32'd1000, 16'd5, 0);          // empty upper half
        add_item(32'd0, 16'hFFFF, 0);          // below lower max, crosses up
        add_item(32'hFFFF_FFFF, 16'd0, 0);     // above upper min, crosses down
        add_item(32'hFFFF_FFFF, 16'hFFFF, 0);  // equal to upper min
        add_item(32'd1000, 16'd1, 0);          // equal to lower max
        add_item(32'd1000, 16'd2, 0);
        add_item(32'd0, 16'd0, 0);
        add_item(32'd500, 16'h8000, 0);
        add_item(32'h8000_0000, 16'h7FFF, 0);
        add_item(32'h7FFF_FFFF, 16'h0001, 0);
        add_item(32'h5555_5555, 16'hAAAA, 0);
        add_item(32'hAAAA_AAAA, 16'h5555, 0);
        add_item(32'd1, 16'd3, 0);
        add_item(32'hFFFF_FFFE, 16'd4, 0);
        add_item(32'd999, 16'd6, 1);           // sender drains before this one

        // random: wide keys, clustered keys for ties, weight extremes; fills capacity
        for (int n = 0; n < NumRandom; n++) begin
            case ($urandom_range(0, 3))
                0: k = 32'($urandom_range(0, 63));
                1: k = 32'hFFFF_FFC0 | 32'($urandom_range(0, 63));
                default: k = 32'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0: w = 16'hFFFF;
                1: w = 16'd0;
                default: w = 16'($urandom);
            endcase
            add_item(k, w, n == 400 || n == 1100);
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        while (item_queue.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0) begin
            $display("running_median_split_sum_top_test OK");
        end else begin
            $display("running_median_split_sum_top_test NOT OK");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("running_median_split_sum_top_test NOT OK");
        $finish;
    end

endmodule
